// ----- rtl/core/rtwc_pkg.sv -----
// ----------------------------------------------------------------------------
// Route time window check package
// Shared widths, register indexes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package rtwc_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int TIME_WIDTH_DEF  = 32;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_ENABLE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEPOT_X       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEPOT_Y       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEPOT_SERVICE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEPOT_DUE     = 3'd4;

  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LATE_CUSTOMER = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LATE_DEPOT    = 2'd2;

  localparam logic MODE_VISIT = 1'b0;
  localparam logic MODE_CLOSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_ARRIVE,
    ST_WINDOW,
    ST_SERVE,
    ST_DONE
  } rtwc_state_t;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_SQUARE,
    DS_ROOT
  } rtwc_dist_state_t;

endpackage

// ----- rtl/core/rtwc_dist.sv -----
// ----------------------------------------------------------------------------
// Route time window check distance unit
// Bit-serial Euclidean distance: floor(sqrt(dx*dx + dy*dy)), one bit a cycle.
// ----------------------------------------------------------------------------
module rtwc_dist
  import rtwc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  output logic                          done,
  output logic        [COORD_WIDTH:0]   leg_len
);

  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int SUM_W  = 2 * MAG_W;
  localparam int ROOT_W = MAG_W;
  localparam int CNT_W  = $clog2(MAG_W);

  rtwc_dist_state_t phase;
  rtwc_dist_state_t phase_next;

  logic [MAG_W-1:0]  mx;
  logic [MAG_W-1:0]  my;
  logic [SUM_W-1:0]  sx;
  logic [SUM_W-1:0]  sy;
  logic [SUM_W-1:0]  acc;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  cnt;
  logic              last_step;

  logic signed [MAG_W-1:0] diff_x;
  logic signed [MAG_W-1:0] diff_y;
  logic        [MAG_W-1:0] abs_x;
  logic        [MAG_W-1:0] abs_y;
  logic        [SUM_W-1:0] add_x;
  logic        [SUM_W-1:0] add_y;
  logic        [ROOT_W+1:0] rem_sh;
  logic        [ROOT_W+1:0] trial;
  logic                     take;

  assign diff_x = {ax[COORD_WIDTH-1], ax} - {bx[COORD_WIDTH-1], bx};
  assign diff_y = {ay[COORD_WIDTH-1], ay} - {by[COORD_WIDTH-1], by};
  assign abs_x  = diff_x[MAG_W-1] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
  assign abs_y  = diff_y[MAG_W-1] ? MAG_W'(-diff_y) : MAG_W'(diff_y);

  assign add_x  = mx[0] ? sx : '0;
  assign add_y  = my[0] ? sy : '0;

  assign rem_sh = {rem[ROOT_W-1:0], acc[SUM_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign take   = (rem_sh >= trial);

  assign last_step = (cnt == CNT_W'(MAG_W - 1));
  assign leg_len   = root;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DS_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      done  <= (phase == DS_ROOT) && last_step;
      if (phase == DS_IDLE || last_step) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      DS_IDLE: begin
        if (start) begin
          mx  <= abs_x;
          my  <= abs_y;
          sx  <= SUM_W'(abs_x);
          sy  <= SUM_W'(abs_y);
          acc <= '0;
        end
      end
      DS_SQUARE: begin
        acc <= acc + add_x + add_y;
        mx  <= mx >> 1;
        my  <= my >> 1;
        sx  <= sx << 1;
        sy  <= sy << 1;
        rem  <= '0;
        root <= '0;
      end
      DS_ROOT: begin
        acc <= acc << 2;
        if (take) begin
          rem  <= (ROOT_W + 1)'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[ROOT_W:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      DS_IDLE:   if (start) phase_next = DS_SQUARE;
      DS_SQUARE: if (last_step) phase_next = DS_ROOT;
      DS_ROOT:   if (last_step) phase_next = DS_IDLE;
      default:   phase_next = DS_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("distance done held for more than one cycle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (phase == DS_IDLE))
    else $error("distance started while busy");
  a_root_done: assert property (@(posedge clk) disable iff (rst)
    (phase == DS_ROOT) && last_step |=> done && (phase == DS_IDLE))
    else $error("root pass did not finish");
`endif

endmodule

// ----- rtl/core/route_time_window_check_core.sv -----
// ----------------------------------------------------------------------------
// Route time window check core
// Time-window feasibility of vehicle tours, one result word per input word.
// ----------------------------------------------------------------------------
// One word is taken at a time; a close word skips the service step. The
// distance unit forms the sum of squares one bit a cycle and then the square
// root one bit a cycle. A finished result waits in the output register while
// the next word is already being worked on.
module route_time_window_check_core
  import rtwc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  localparam int IN_W        = 2 * COORD_WIDTH + 3 * TIME_WIDTH,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((TIME_WIDTH + 7) / 8) * 8,
  localparam int CFG_W       = (TIME_WIDTH > COORD_WIDTH) ? TIME_WIDTH : COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // visit_x, visit_y, ready_time, due_time, service_time, zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // mode
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // clock_after, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status, any_failure
  output logic [2:0]             m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int ROOT_W = COORD_WIDTH + 1;
  localparam int ADD_W  = ((TIME_WIDTH > ROOT_W) ? TIME_WIDTH : ROOT_W) + 1;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  rtwc_state_t state;
  rtwc_state_t state_next;

  logic                          check_enable;
  logic signed [COORD_WIDTH-1:0] depot_x;
  logic signed [COORD_WIDTH-1:0] depot_y;
  logic        [TIME_WIDTH-1:0]  depot_service;
  logic        [TIME_WIDTH-1:0]  depot_due;

  logic        [TIME_WIDTH-1:0]  elapsed_time;
  logic signed [COORD_WIDTH-1:0] last_x;
  logic signed [COORD_WIDTH-1:0] last_y;
  logic                          failure_seen;

  logic                          mode;
  logic signed [COORD_WIDTH-1:0] visit_x;
  logic signed [COORD_WIDTH-1:0] visit_y;
  logic        [TIME_WIDTH-1:0]  ready_time;
  logic        [TIME_WIDTH-1:0]  due_time;
  logic        [TIME_WIDTH-1:0]  service_time;

  logic        [TIME_WIDTH-1:0]  clock_now;
  logic        [STATUS_W-1:0]    status;

  logic                          in_accept;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic                          dist_done;
  logic        [ROOT_W-1:0]      leg_len;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;
  logic        [ADD_W-1:0]       arrive_sum;
  logic        [TIME_WIDTH:0]    serve_sum;
  logic        [TIME_WIDTH-1:0]  waited;
  logic                          out_free;
  logic                          fail_now;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign in_x      = s_tdata[COORD_WIDTH-1:0];
  assign in_y      = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign target_x  = (s_tuser == MODE_CLOSE) ? depot_x : in_x;
  assign target_y  = (s_tuser == MODE_CLOSE) ? depot_y : in_y;

  assign arrive_sum = ADD_W'(elapsed_time) + ADD_W'(leg_len);
  assign serve_sum  = {1'b0, clock_now} + {1'b0, service_time};
  assign waited     = (clock_now < ready_time) ? ready_time : clock_now;
  assign out_free   = !m_tvalid || m_tready;
  assign fail_now   = (status != STATUS_OK);

  rtwc_dist #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept),
    .ax     (last_x),
    .ay     (last_y),
    .bx     (target_x),
    .by     (target_y),
    .done   (dist_done),
    .leg_len(leg_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable  <= 1'b1;
      depot_x       <= '0;
      depot_y       <= '0;
      depot_service <= '0;
      depot_due     <= TIME_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHECK_ENABLE:  check_enable  <= cfg_data[0];
        CFG_DEPOT_X:       depot_x       <= cfg_data[COORD_WIDTH-1:0];
        CFG_DEPOT_Y:       depot_y       <= cfg_data[COORD_WIDTH-1:0];
        CFG_DEPOT_SERVICE: depot_service <= cfg_data[TIME_WIDTH-1:0];
        CFG_DEPOT_DUE:     depot_due     <= cfg_data[TIME_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      elapsed_time <= '0;
      last_x       <= '0;
      last_y       <= '0;
      failure_seen <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        m_tvalid     <= 1'b1;
        failure_seen <= failure_seen || fail_now;
        if (mode == MODE_CLOSE) begin
          elapsed_time <= depot_service;
          last_x       <= depot_x;
          last_y       <= depot_y;
        end else begin
          elapsed_time <= clock_now;
          last_x       <= visit_x;
          last_y       <= visit_y;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode         <= s_tuser;
      visit_x      <= in_x;
      visit_y      <= in_y;
      ready_time   <= s_tdata[2*COORD_WIDTH +: TIME_WIDTH];
      due_time     <= s_tdata[2*COORD_WIDTH+TIME_WIDTH +: TIME_WIDTH];
      service_time <= s_tdata[2*COORD_WIDTH+2*TIME_WIDTH +: TIME_WIDTH];
      status       <= STATUS_OK;
    end
    case (state)
      ST_ARRIVE: begin
        clock_now <= (arrive_sum > ADD_W'(TIME_MAX)) ? TIME_MAX
                                                     : arrive_sum[TIME_WIDTH-1:0];
      end
      ST_WINDOW: begin
        if (mode == MODE_CLOSE) begin
          if (check_enable && (clock_now > depot_due)) begin
            status <= STATUS_LATE_DEPOT;
          end
        end else begin
          clock_now <= waited;
          if (check_enable && (waited > due_time)) begin
            status <= STATUS_LATE_CUSTOMER;
          end
        end
      end
      ST_SERVE: begin
        clock_now <= serve_sum[TIME_WIDTH] ? TIME_MAX : serve_sum[TIME_WIDTH-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= OUT_TDATA_W'(clock_now);
          m_tuser <= {failure_seen || fail_now, status};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_accept) state_next = ST_DIST;
      ST_DIST:   if (dist_done) state_next = ST_ARRIVE;
      ST_ARRIVE: state_next = ST_WINDOW;
      ST_WINDOW: state_next = (mode == MODE_CLOSE) ? ST_DONE : ST_SERVE;
      ST_SERVE:  state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    failure_seen |=> failure_seen)
    else $error("failure flag cleared");
  a_fail_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[STATUS_W-1:0] != STATUS_OK) |-> m_tuser[STATUS_W])
    else $error("late result without failure flag");
  a_accept_dist: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_DIST))
    else $error("accepted word did not start distance");
  a_done_in_dist: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> (state == ST_DIST))
    else $error("distance finished outside distance wait");
`endif

endmodule

// ----- bench/tb_route_time_window_check_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route time window check core testbench
// Drives visit and close words through the core with random idling on both
// sides, predicts each result word from its own tour model and compares the
// status, clock and sticky flag of every result against that prediction.
// ----------------------------------------------------------------------------
module tb_route_time_window_check_core;
  import rtwc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int TW = TIME_WIDTH_DEF;
  localparam int IN_TDATA_W = ((2 * CW + 3 * TW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((TW + 7) / 8) * 8;
  localparam int CFG_W = (TW > CW) ? TW : CW;
  localparam longint unsigned TIME_TOP = (64'd1 << TW) - 64'd1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_WORDS = 380;

  typedef struct packed {
    logic          mode;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [TW-1:0] ready;
    logic [TW-1:0] due;
    logic [TW-1:0] service;
  } stop_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TW-1:0]       clock_after;
    logic                any_failure;
  } window_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [2:0]             m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  route_time_window_check_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Tour model: configuration copy and running state.
  logic          chk_en = 1'b1;
  logic [CW-1:0] dep_x = '0;
  logic [CW-1:0] dep_y = '0;
  logic [TW-1:0] dep_service = '0;
  logic [TW-1:0] dep_due = '1;
  logic [TW-1:0] run_time = '0;
  logic [CW-1:0] pos_x = '0;
  logic [CW-1:0] pos_y = '0;
  logic          late_seen = 1'b0;

  stop_word_t     pending_words[$];
  window_report_t awaited_reports[$];
  int  words_queued = 0;
  int  words_taken = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  logic word_taken = 1'b0;
  logic idle_on = 1'b0;
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;
  int  send_gap = 0;
  logic gap_chain = 1'b0;
  int  stall_left = 0;

  function automatic longint unsigned leg_length(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                                 logic [CW-1:0] bx, logic [CW-1:0] by);
    longint dx;
    longint dy;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    dx = longint'($signed(ax)) - longint'($signed(bx));
    dy = longint'($signed(ay)) - longint'($signed(by));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = dx * dx + dy * dy;
    root = 0;
    for (int b = CW + 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root;
  endfunction

  function automatic logic [TW-1:0] clamp_add(logic [TW-1:0] a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > TIME_TOP) ? '1 : s[TW-1:0];
  endfunction

  task automatic advance_tour(logic mode, logic [IN_TDATA_W-1:0] word);
    window_report_t rep;
    logic [TW-1:0] t;
    logic [CW-1:0] vx;
    logic [CW-1:0] vy;
    vx = word[CW-1:0];
    vy = word[2*CW-1:CW];
    rep.status = STATUS_OK;
    if (mode == MODE_VISIT) begin
      t = clamp_add(run_time, leg_length(pos_x, pos_y, vx, vy));
      if (t < word[2*CW +: TW]) t = word[2*CW +: TW];
      if (chk_en && t > word[2*CW+TW +: TW]) rep.status = STATUS_LATE_CUSTOMER;
      t = clamp_add(t, longint'(word[2*CW+2*TW +: TW]));
      run_time = t;
      pos_x = vx;
      pos_y = vy;
    end else begin
      t = clamp_add(run_time, leg_length(pos_x, pos_y, dep_x, dep_y));
      if (chk_en && t > dep_due) rep.status = STATUS_LATE_DEPOT;
      run_time = dep_service;
      pos_x = dep_x;
      pos_y = dep_y;
    end
    if (rep.status != STATUS_OK) late_seen = 1'b1;
    rep.clock_after = t;
    rep.any_failure = late_seen;
    awaited_reports.push_back(rep);
  endtask

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    window_report_t rep;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        advance_tour(s_tuser, s_tdata);
        word_taken = 1'b1;
        words_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (awaited_reports.size() == 0) begin
          note_mismatch("result word with none expected", 64'(m_tdata), 64'(0));
        end else begin
          rep = awaited_reports.pop_front();
          if (m_tuser[1:0] !== rep.status)
            note_mismatch("status", 64'(m_tuser[1:0]), 64'(rep.status));
          if (m_tdata[TW-1:0] !== rep.clock_after)
            note_mismatch("clock_after", 64'(m_tdata[TW-1:0]), 64'(rep.clock_after));
          if (m_tuser[2] !== rep.any_failure)
            note_mismatch("any_failure", 64'(m_tuser[2]), 64'(rep.any_failure));
        end
      end
    end
  end

  // Sender: an offered word stays until taken; idle stretches are chained bursts.
  always @(negedge clk) begin : sender
    stop_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !word_taken)) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0 && idle_on &&
                   $urandom_range(0, gap_chain ? 7 : 2) != 0) begin
        send_gap = $urandom_range(1, 9) - 1;
        gap_chain = 1'b1;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        gap_chain = 1'b0;
        s_tvalid <= 1'b1;
        s_tdata <= {w.service, w.due, w.ready, w.y, w.x};
        s_tuser <= w.mode;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_hold;
    end
  end

  initial begin : long_stall
    wait (hold_req);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CHECK_ENABLE:  chk_en = value[0];
      CFG_DEPOT_X:       dep_x = value[CW-1:0];
      CFG_DEPOT_Y:       dep_y = value[CW-1:0];
      CFG_DEPOT_SERVICE: dep_service = value[TW-1:0];
      CFG_DEPOT_DUE:     dep_due = value[TW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_depot(logic en, logic [CW-1:0] x, logic [CW-1:0] y,
                           logic [TW-1:0] svc, logic [TW-1:0] due);
    write_reg(CFG_CHECK_ENABLE, CFG_W'(en));
    write_reg(CFG_DEPOT_X, CFG_W'($signed(x)));
    write_reg(CFG_DEPOT_Y, CFG_W'($signed(y)));
    write_reg(CFG_DEPOT_SERVICE, svc);
    write_reg(CFG_DEPOT_DUE, due);
  endtask

  task automatic queue_word(logic mode, logic [CW-1:0] x, logic [CW-1:0] y,
                            logic [TW-1:0] ready, logic [TW-1:0] due, logic [TW-1:0] svc);
    stop_word_t w;
    w.mode = mode;
    w.x = x;
    w.y = y;
    w.ready = ready;
    w.due = due;
    w.service = svc;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_close();
    queue_word(MODE_CLOSE, CW'($urandom), CW'($urandom), $urandom, $urandom, $urandom);
  endtask

  function automatic logic [CW-1:0] near_coord();
    int v;
    v = int'($urandom_range(0, 60000)) - 30000;
    return v[CW-1:0];
  endfunction

  // Mostly plausible tours with rising windows, some fully random words.
  task automatic queue_phase(int target);
    int start;
    int visits;
    logic [TW-1:0] base;
    logic [TW-1:0] ready;
    start = words_queued;
    while (words_queued - start < target) begin
      if ($urandom_range(0, 9) < 2) begin
        queue_word(1'($urandom_range(0, 1)), CW'($urandom), CW'($urandom),
                   $urandom, $urandom, $urandom);
      end else begin
        visits = $urandom_range(1, 8);
        base = $urandom_range(0, 1 << 20);
        for (int i = 0; i < visits; i++) begin
          base = base + $urandom_range(0, 30000);
          ready = ($urandom_range(0, 3) == 0) ? '0 : base;
          queue_word(MODE_VISIT, near_coord(), near_coord(), ready,
                     ready + $urandom_range(0, 40000), $urandom_range(0, 2000));
        end
        queue_close();
      end
    end
  endtask

  task automatic wait_drained();
    while (!(words_taken == words_queued && awaited_reports.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [TW-1:0] T_MAX = '1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first tour must ignore these depot values until its first close.
    set_depot(1'b1, CW'(2560), -CW'(5120), TW'(32'h400), TW'(32'h0010_0000));
    queue_word(MODE_VISIT, '0, '0, '0, '0, '0);
    queue_word(MODE_VISIT, CW'(768), CW'(1024), '0, T_MAX, TW'(100));
    queue_word(MODE_VISIT, CW'(768), CW'(1024), TW'(5000), TW'(5000), '0);
    queue_close();
    queue_word(MODE_VISIT, CW'(2560), -CW'(5120), '0, TW'(32'h3FF), TW'(1));
    queue_word(MODE_VISIT, C_MAX, C_MAX, '0, T_MAX, T_MAX);
    queue_word(MODE_VISIT, C_MIN, C_MIN, '0, T_MAX, '0);
    queue_word(MODE_VISIT, C_MIN, C_MAX, '0, T_MAX - 1, '0);
    queue_close();
    queue_close();
    queue_word(MODE_VISIT, C_MAX, C_MIN, T_MAX, T_MAX, '0);
    queue_close();
    wait_drained();
    write_reg(CFG_CHECK_ENABLE, CFG_W'(0));
    queue_word(MODE_VISIT, C_MIN, C_MIN, '0, '0, T_MAX);
    queue_close();
    wait_drained();
    set_depot(1'b1, CW'(2560), -CW'(5120), TW'(32'h400), '0);
    queue_close();
    queue_word(MODE_VISIT, CW'(1), '0, '0, '0, '0);
    wait_drained();

    idle_on = 1'b1;
    set_depot(1'b1, near_coord(), near_coord(), $urandom_range(0, 4096), T_MAX);
    hold_req = 1'b1;
    queue_phase(PHASE_WORDS);
    wait_drained();
    set_depot(1'b1, C_MIN, C_MAX, T_MAX, '0);
    queue_phase(PHASE_WORDS);
    wait_drained();
    set_depot(1'b0, near_coord(), near_coord(), $urandom, $urandom);
    queue_phase(PHASE_WORDS);
    wait_drained();
    set_depot(1'b1, C_MAX, C_MIN, '0, $urandom_range(32'h1_0000, 32'h10_0000));
    queue_phase(PHASE_WORDS);
    wait_drained();
    idle_on = 1'b0;
    set_depot(1'b1, near_coord(), near_coord(), $urandom_range(0, 1 << 20), $urandom);
    queue_phase(PHASE_WORDS);
    wait_drained();

    if (awaited_reports.size() != 0)
      note_mismatch("result words never produced", 64'(0), 64'(awaited_reports.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rtwc_pkg.sv
rtl/core/rtwc_dist.sv
rtl/core/route_time_window_check_core.sv
bench/tb_route_time_window_check_core.sv
